### rtl/core/ctg_pkg.sv
// ============================================================================
// ctg_pkg - cadenced tone generator shared definitions
// Widths, register indexes, Q30 constants, microcode format and program ROM.
// ============================================================================
package ctg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int COUNT_BITS = 25;

  localparam int SAMPLE_W  = 16;
  localparam int AMP_W     = 16;
  localparam int PSTEP_W   = 32;
  localparam int LEN_W     = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PERIOD_W  = LEN_W + 1;
  localparam int CMP_W     = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;

  localparam int OPND_W = 32;
  localparam int PROD_W = 2 * OPND_W;
  localparam int Q30_W  = 31;   // |z|, z^2, gain: all fit below 2^31

  localparam logic [OPND_W-1:0] PI_Q30 = 32'd3373259426;
  localparam logic [OPND_W-1:0] B_Q30  = 32'd1377809732;  // 2*pi - 5
  localparam logic [OPND_W-1:0] C_Q30  = 32'd152033954;   // pi - 3

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'd32767;

  localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 16'd32768;
  localparam logic [PSTEP_W-1:0] RST_PSTEP     = 32'd228170138;
  localparam logic [LEN_W-1:0]   RST_TONE_LEN  = 24'd8000;
  localparam logic [LEN_W-1:0]   RST_PAUSE_LEN = 24'd32000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_AMPLITUDE,
    CFG_PHASE_STEP,
    CFG_TONE_LEN,
    CFG_PAUSE_LEN
  } cfg_idx_t;

  // multiplier operand selects
  typedef enum logic [1:0] {
    OPA_ZABS,
    OPA_CQ30,
    OPA_Z2,
    OPA_GAIN
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_ZABS,
    OPB_P30,   // product >> 30
    OPB_T1,    // B - (product >> 30)
    OPB_T2,    // pi - (product >> 30)
    OPB_P31    // product >> 31
  } opb_sel_t;

  typedef struct packed {
    logic     en;
    opa_sel_t sel_a;
    opb_sel_t sel_b;
  } mul_ctl_t;

  typedef enum logic [1:0] {
    WT_NONE,
    WT_IN,
    WT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NOT_TONE
  } jump_t;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_SQUARE = 3'd1;
  localparam upc_t UPC_CZ2    = 3'd2;
  localparam upc_t UPC_Z2T1   = 3'd3;
  localparam upc_t UPC_ZT2    = 3'd4;
  localparam upc_t UPC_GAIN   = 3'd5;
  localparam upc_t UPC_SCALE  = 3'd6;
  localparam upc_t UPC_EMIT   = 3'd7;

  typedef struct packed {
    wait_t    wait_on;
    jump_t    jump;
    upc_t     target;
    mul_ctl_t mul;
    logic     z2_we;
    logic     res_we;
    logic     emit;
  } ucode_t;

  // program ROM
  function automatic ucode_t ctg_ucode(upc_t upc);
    ucode_t uc;
    uc = '0;
    case (upc)
      UPC_WAIT: begin
        uc.wait_on = WT_IN;
        uc.jump    = JC_NOT_TONE;
        uc.target  = UPC_EMIT;
      end
      UPC_SQUARE: begin
        uc.mul = '{en: 1'b1, sel_a: OPA_ZABS, sel_b: OPB_ZABS};
      end
      UPC_CZ2: begin
        uc.z2_we = 1'b1;
        uc.mul   = '{en: 1'b1, sel_a: OPA_CQ30, sel_b: OPB_P30};
      end
      UPC_Z2T1: begin
        uc.mul = '{en: 1'b1, sel_a: OPA_Z2, sel_b: OPB_T1};
      end
      UPC_ZT2: begin
        uc.mul = '{en: 1'b1, sel_a: OPA_ZABS, sel_b: OPB_T2};
      end
      UPC_GAIN: begin
        uc.mul = '{en: 1'b1, sel_a: OPA_GAIN, sel_b: OPB_P31};
      end
      UPC_SCALE: begin
        uc.res_we = 1'b1;
      end
      UPC_EMIT: begin
        uc.wait_on = WT_OUT;
        uc.emit    = 1'b1;
        uc.jump    = JC_ALWAYS;
        uc.target  = UPC_WAIT;
      end
      default: begin
        uc.jump   = JC_ALWAYS;
        uc.target = UPC_WAIT;
      end
    endcase
    return uc;
  endfunction

endpackage

### rtl/core/ctg_stream_if.sv
// ============================================================================
// ctg_stream_if - sample stream channel
// Valid/ready channel carrying one signed 16-bit audio sample per transfer.
// ============================================================================
interface ctg_stream_if
  import ctg_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/core/ctg_mul_unit.sv
// ============================================================================
// ctg_mul_unit - shared polynomial multiplier
// Operand selection, Q30 subtractions and one registered 32x32 product.
// ============================================================================
module ctg_mul_unit
  import ctg_pkg::*;
(
  input  logic              clk,
  input  mul_ctl_t          ctl,
  input  logic [Q30_W-1:0]  zabs,
  input  logic [Q30_W-1:0]  z2,
  input  logic [Q30_W-1:0]  gain,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;
  logic [OPND_W-1:0] p30;
  logic [OPND_W-1:0] p31;
  logic [OPND_W-1:0] op_a;
  logic [OPND_W-1:0] op_b;

  // feedback from the previous product, back in Q30
  assign p30 = prod_r[61:30];
  assign p31 = prod_r[62:31];

  always_comb begin
    case (ctl.sel_a)
      OPA_ZABS: op_a = OPND_W'(zabs);
      OPA_CQ30: op_a = C_Q30;
      OPA_Z2:   op_a = OPND_W'(z2);
      OPA_GAIN: op_a = OPND_W'(gain);
      default:  op_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.sel_b)
      OPB_ZABS: op_b = OPND_W'(zabs);
      OPB_P30:  op_b = p30;
      OPB_T1:   op_b = B_Q30 - p30;
      OPB_T2:   op_b = PI_Q30 - p30;
      OPB_P31:  op_b = p31;
      default:  op_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/core/cadenced_tone_generator_core.sv
// ============================================================================
// cadenced_tone_generator_core - DDS sine tone with on/off cadence
// Microcoded sequencer around one shared multiplier; register write port.
// ============================================================================
// One sample in, one sample out. Disabled, the input sample is returned
// unchanged. Enabled, a sine tone is returned for the first tone_len samples
// of each tone_len + pause_len period and zero for the rest. A tone sample
// runs through the accept step, five chained products on the single
// registered 32x32 multiplier, a scale/saturate step and the emit step, all
// stepped by the 8-word microcode ROM. Pass-through and silent samples jump
// straight to emit; every result is registered at the emit step. The next
// sample is taken once the sequencer is back at its wait step, while an
// earlier result may still sit in the output register; the emit step holds
// only if that register is still full.
module cadenced_tone_generator_core
  import ctg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ctg_stream_if.sink           in_chan,
  ctg_stream_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic                  enable_r;
  logic [AMP_W-1:0]      amp_r;
  logic [PSTEP_W-1:0]    pstep_r;
  logic [LEN_W-1:0]      tone_len_r;
  logic [LEN_W-1:0]      pause_len_r;

  logic [PHASE_BITS-1:0] phase_r,  phase_nxt;
  logic [COUNT_BITS-1:0] count_r,  count_nxt;
  upc_t                  upc_r,    upc_nxt;
  logic                  out_valid_r;

  logic [Q30_W-1:0]      zabs_r;
  logic                  neg_r;
  logic [Q30_W-1:0]      gain_r;
  logic [Q30_W-1:0]      z2_r;
  logic [SAMPLE_W-1:0]   res_r;
  logic [SAMPLE_W-1:0]   out_sample_r;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  ucode_t uc;
  logic   in_xfer;
  logic   stall;
  logic   tone_go;
  logic   take_jump;

  assign uc      = ctg_ucode(upc_r);
  assign in_xfer = in_chan.valid && in_chan.ready;
  assign stall   = ((uc.wait_on == WT_IN) && !in_xfer) ||
                   ((uc.wait_on == WT_OUT) && out_valid_r && !out_chan.ready);

  assign take_jump = (uc.jump == JC_ALWAYS) || ((uc.jump == JC_NOT_TONE) && !tone_go);

  always_comb begin
    if (stall) begin
      upc_nxt = upc_r;
    end else if (take_jump) begin
      upc_nxt = uc.target;
    end else begin
      upc_nxt = upc_r + 3'd1;
    end
  end

  assign in_chan.ready = (uc.wait_on == WT_IN);

  // --------------------------------------------------------------------------
  // cadence and phase
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0]   period_c;
  logic [COUNT_BITS-1:0] count_inc;

  assign period_c  = PERIOD_W'(tone_len_r) + PERIOD_W'(pause_len_r);
  assign count_inc = count_r + COUNT_BITS'(1);
  assign tone_go   = enable_r && (CMP_W'(count_r) < CMP_W'(tone_len_r));

  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    if (in_xfer && enable_r) begin
      // wrap also catches a stale count left over from a shorter period
      count_nxt = (CMP_W'(count_inc) >= CMP_W'(period_c)) ? '0 : count_inc;
      if (tone_go) begin
        phase_nxt = phase_r + PHASE_BITS'(pstep_r);
      end
    end
  end

  // top 32 bits of the accumulator, zero-filled when it is narrower
  logic [PHASE_BITS+31:0] phase_ext;
  logic [31:0]            w;
  logic                   second_half;
  logic [31:0]            w_fold;
  logic [31:0]            w_abs;

  assign phase_ext   = {phase_r, 32'd0};
  assign w           = phase_ext[PHASE_BITS+31 -: 32];
  assign second_half = w[31] ^ w[30];
  // second half wave: shift by half a period, z = w / 2^30 in [-1, 1)
  assign w_fold      = {w[31] ^ second_half, w[30:0]};
  assign w_abs       = w_fold[31] ? (~w_fold + 32'd1) : w_fold;

  // --------------------------------------------------------------------------
  // multiplier
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;

  ctg_mul_unit u_mul (
    .clk  (clk),
    .ctl  (uc.mul),
    .zabs (zabs_r),
    .z2   (z2_r),
    .gain (gain_r),
    .prod (prod)
  );

  // magnitude = (32767 * amplitude * y) >> 46, then saturate and sign
  logic [16:0]         mag_raw;
  logic [SAMPLE_W-1:0] mag_sat;
  logic [SAMPLE_W-1:0] tone_val;

  assign mag_raw  = prod[62:46];
  assign mag_sat  = (mag_raw > 17'(SAT_MAX)) ? SAT_MAX : mag_raw[SAMPLE_W-1:0];
  assign tone_val = neg_r ? (~mag_sat + 16'd1) : mag_sat;   // -0 stays 0

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      amp_r       <= RST_AMPLITUDE;
      pstep_r     <= RST_PSTEP;
      tone_len_r  <= RST_TONE_LEN;
      pause_len_r <= RST_PAUSE_LEN;
      phase_r     <= '0;
      count_r     <= '0;
      upc_r       <= UPC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     enable_r    <= cfg_data[0];
          CFG_AMPLITUDE:  amp_r       <= cfg_data[AMP_W-1:0];
          CFG_PHASE_STEP: pstep_r     <= cfg_data[PSTEP_W-1:0];
          CFG_TONE_LEN:   tone_len_r  <= cfg_data[LEN_W-1:0];
          CFG_PAUSE_LEN:  pause_len_r <= cfg_data[LEN_W-1:0];
          default:        ;
        endcase
      end
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      upc_r   <= upc_nxt;
      if (uc.emit && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      zabs_r <= w_abs[Q30_W-1:0];
      neg_r  <= w_fold[31] ^ second_half;
      gain_r <= Q30_W'({amp_r, 15'd0}) - Q30_W'(amp_r);   // 32767 * amplitude
      if (!enable_r) begin
        res_r <= in_chan.sample;
      end else if (!tone_go) begin
        res_r <= '0;
      end
    end
    if (uc.z2_we) begin
      z2_r <= prod[60:30];
    end
    if (uc.res_we) begin
      res_r <= tone_val;
    end
    if (uc.emit && !stall) begin
      out_sample_r <= res_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = out_sample_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && tone_go) |=> (phase_r == $past(phase_r + PHASE_BITS'(pstep_r))))
    else $error("phase accumulator did not advance on a tone sample");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && enable_r && !cfg_we) |=>
      ((count_r == '0) || (CMP_W'(count_r) < CMP_W'($past(period_c)))))
    else $error("cadence count left the period");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(upc_r) == UPC_EMIT))
    else $error("result presented outside the emit step");

endmodule

### tb/cadenced_tone_generator_core_test.sv
// ============================================================================
// cadenced_tone_generator_core_test - self-checking bench for the tone core
// Drives random and directed samples across many register settings, predicts
// every output sample (pass-through, silence or polynomial sine) and checks
// each transfer on the result channel against the oldest prediction.
// ============================================================================
module cadenced_tone_generator_core_test;
  import ctg_pkg::*;

  // Q30 polynomial constants: pi, 2*pi - 5, pi - 3
  localparam logic [63:0] PI_FIX = 64'd3373259426;
  localparam logic [63:0] B_FIX  = 64'd1377809732;
  localparam logic [63:0] C_FIX  = 64'd152033954;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int IDLE_PCT     = 33;
  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE_CYC   = 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ctg_stream_if in_if ();
  ctg_stream_if out_if ();

  cadenced_tone_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the core: register copies plus phase and cadence state
  // --------------------------------------------------------------------------
  logic                  sh_enable;
  logic [AMP_W-1:0]      sh_amplitude;
  logic [PSTEP_W-1:0]    sh_phase_step;
  logic [LEN_W-1:0]      sh_tone_len;
  logic [LEN_W-1:0]      sh_pause_len;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [COUNT_BITS-1:0] cadence_cnt;

  logic signed [SAMPLE_W-1:0] sample_backlog[$];    // waiting for the driver
  logic signed [SAMPLE_W-1:0] expected_samples[$];  // predicted, not yet seen

  int  errors;
  int  n_checked;
  int  n_passed;
  int  n_tone;
  int  n_silent;
  int  n_settings;
  bit  steady_flow;  // both sides stream without idling while set

  // Sine from the phase word. The top two bits pick the half wave; z is the
  // phase folded to [-1, 1) in Q30 and the odd polynomial runs on |z|. Each
  // product is floored back to Q30, then scaled by 32767 * gain.
  function automatic logic [SAMPLE_W-1:0] sine_sample(input logic [31:0] acc,
                                                      input logic [AMP_W-1:0] gain);
    logic [31:0] w;
    logic        second_half;
    logic        neg;
    logic [63:0] a;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] mag;
    w           = acc;
    second_half = w[31] ^ w[30];
    if (second_half) begin
      w = w - 32'h8000_0000;
    end
    neg = w[31];
    a   = neg ? {32'd0, ~w + 32'd1} : {32'd0, w};
    if (second_half) begin
      neg = ~neg;
    end
    z2  = (a * a) >> 30;
    t   = B_FIX - ((C_FIX * z2) >> 30);
    t   = PI_FIX - ((z2 * t) >> 30);
    y   = (a * t) >> 31;
    mag = (64'd32767 * 64'(gain) * y) >> 46;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    // a zero magnitude never turns negative
    if (neg && mag != 64'd0) begin
      return ~mag[15:0] + 16'd1;
    end
    return mag[15:0];
  endfunction

  // Output for one accepted sample; advances the shadow state.
  function automatic logic [SAMPLE_W-1:0] predict_output(input logic [SAMPLE_W-1:0] din);
    logic [SAMPLE_W-1:0]   res;
    logic [COUNT_BITS:0]   period;
    logic [COUNT_BITS-1:0] nxt;
    if (!sh_enable) begin
      n_passed = n_passed + 1;
      return din;
    end
    res = '0;
    // phase only moves on tone samples
    if (cadence_cnt < COUNT_BITS'(sh_tone_len)) begin
      res       = sine_sample(phase_acc, sh_amplitude);
      phase_acc = phase_acc + sh_phase_step;
      n_tone    = n_tone + 1;
    end else begin
      n_silent = n_silent + 1;
    end
    // wrap at the period; a stale count past a shortened period, or a zero
    // period, also lands on 0
    period = (COUNT_BITS+1)'(sh_tone_len) + (COUNT_BITS+1)'(sh_pause_len);
    nxt    = cadence_cnt + COUNT_BITS'(1);
    if ((COUNT_BITS+1)'(nxt) >= period) begin
      nxt = '0;
    end
    cadence_cnt = nxt;
    return res;
  endfunction

  // Register data with random bits above the register width.
  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] value,
                                                 input int width);
    logic [CFG_W-1:0] mask;
    mask = (width >= CFG_W) ? '1 : ((32'd1 << width) - 32'd1);
    return (CFG_W'($urandom) & ~mask) | (value & mask);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: holds a sample until its transfer, idles at random between
  // samples. The prediction is taken at the transfer edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_samples.push_back(predict_output(in_if.sample));
      end
      if (!in_if.valid || in_if.ready) begin
        if (sample_backlog.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          in_if.valid  <= 1'b1;
          in_if.sample <= sample_backlog.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      if (out_if.valid && out_if.ready) begin
        n_checked = n_checked + 1;
        if (expected_samples.size() == 0) begin
          $error("out_sample: unexpected transfer, actual %0d", out_if.sample);
          errors = errors + 1;
        end else begin
          want = expected_samples.pop_front();
          if (out_if.sample !== want) begin
            $error("out_sample mismatch: expected %0d, actual %0d", want, out_if.sample);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register access: one write per cycle, shadow updated alongside. Only
  // called with the core idle, so no transfer can see a half-done update.
  // --------------------------------------------------------------------------
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_ENABLE:     sh_enable     = data[0];
      CFG_AMPLITUDE:  sh_amplitude  = data[AMP_W-1:0];
      CFG_PHASE_STEP: sh_phase_step = data[PSTEP_W-1:0];
      CFG_TONE_LEN:   sh_tone_len   = data[LEN_W-1:0];
      CFG_PAUSE_LEN:  sh_pause_len  = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings = n_settings + 1;
  endtask

  task automatic set_regs(input logic en, input logic [AMP_W-1:0] amp,
                          input logic [PSTEP_W-1:0] step,
                          input logic [LEN_W-1:0] tone_len,
                          input logic [LEN_W-1:0] pause_len);
    cfg_put(CFG_ENABLE,     with_junk(CFG_W'(en), 1));
    cfg_put(CFG_AMPLITUDE,  with_junk(CFG_W'(amp), AMP_W));
    cfg_put(CFG_PHASE_STEP, step);
    cfg_put(CFG_TONE_LEN,   with_junk(CFG_W'(tone_len), LEN_W));
    cfg_put(CFG_PAUSE_LEN,  with_junk(CFG_W'(pause_len), LEN_W));
    cfg_done();
  endtask

  // queue random samples off the clock edge so the driver sees them cleanly
  task automatic load(input int n);
    @(negedge clk);
    repeat (n) sample_backlog.push_back(SAMPLE_W'($urandom));
  endtask

  // wait until every sample went through and every result came back
  task automatic drain();
    @(negedge clk);
    while (sample_backlog.size() != 0 || in_if.valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic play(input logic en, input logic [AMP_W-1:0] amp,
                      input logic [PSTEP_W-1:0] step,
                      input logic [LEN_W-1:0] tone_len,
                      input logic [LEN_W-1:0] pause_len, input int n);
    set_regs(en, amp, step, tone_len, pause_len);
    load(n);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               random_items;
    int               n;
    bit               long_done;
    logic             en;
    logic [AMP_W-1:0] amp;
    logic [31:0]      step;
    logic [LEN_W-1:0] tone_len;
    logic [LEN_W-1:0] pause_len;

    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    steady_flow   = 1'b0;
    errors        = 0;
    n_checked     = 0;
    n_passed      = 0;
    n_tone        = 0;
    n_silent      = 0;
    n_settings    = 0;
    sh_enable     = 1'b0;
    sh_amplitude  = RST_AMPLITUDE;
    sh_phase_step = RST_PSTEP;
    sh_tone_len   = RST_TONE_LEN;
    sh_pause_len  = RST_PAUSE_LEN;
    phase_acc     = '0;
    cadence_cnt   = '0;
    random_items  = 0;
    long_done     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset the core is disabled: samples come straight back
    @(negedge clk);
    sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'h7FFF);
    sample_backlog.push_back(16'h5555);
    sample_backlog.push_back(16'hAAAA);
    drain();

    // spare indexes must be dropped; enabling alone runs the reset tone
    cfg_put(CFG_SPARE_LO, $urandom);
    cfg_put(CFG_SPARE_HI, $urandom);
    cfg_put(CFG_ENABLE, with_junk(CFG_W'(1'b1), 1));
    cfg_done();
    load(2);
    drain();

    // quarter-wave steps at full gain put one sample in each quarter of the wave
    play(1'b1, 16'hFFFF, 32'h4000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 4);
    // zero gain with a random step, then the largest step at unit gain
    play(1'b1, 16'h0000, $urandom, 24'd5, 24'd5, 2);
    play(1'b1, 16'h0001, 32'hFFFF_FFFF, 24'd2, 24'd1, 2);
    // zero tone length: silent, phase frozen
    play(1'b1, AMP_W'($urandom), $urandom, 24'd0, 24'd3, 2);
    // zero period: count pinned at 0
    play(1'b1, AMP_W'($urandom), $urandom, 24'd0, 24'd0, 2);
    // build up a count, then shorten the period below it
    play(1'b1, AMP_W'($urandom), $urandom, 24'd2, 24'd10, 5);
    play(1'b1, AMP_W'($urandom), $urandom, 24'd2, 24'd1, 3);

    // random settings; short cadences so wraps happen often, a few huge ones
    while (random_items < RANDOM_ITEMS) begin
      en = ($urandom_range(99) < 85);
      case ($urandom_range(9))
        0:       amp = '0;
        1:       amp = '1;
        default: amp = AMP_W'($urandom);
      endcase
      case ($urandom_range(7))
        0:       step = '0;
        1:       step = '1;
        2:       step = $urandom_range(32'h0010_0000);
        default: step = $urandom;
      endcase
      tone_len  = ($urandom_range(99) < 5) ? 24'hFF_FFFF : 24'($urandom_range(40));
      pause_len = ($urandom_range(99) < 5) ? 24'hFF_FFFF : 24'($urandom_range(40));
      if (!long_done && random_items >= 500) begin
        // one long stretch with no idling on either side
        long_done = 1'b1;
        n         = 250;
        en        = 1'b1;
        @(negedge clk);
        steady_flow = 1'b1;
      end else begin
        n = $urandom_range(10, 90);
      end
      play(en, amp, step, tone_len, pause_len, n);
      steady_flow  = 1'b0;
      random_items = random_items + n;
    end

    if (expected_samples.size() != 0) begin
      $error("out_sample: %0d expected results never arrived", expected_samples.size());
      errors = errors + 1;
    end
    $display("Checked %0d output samples over %0d register settings:", n_checked, n_settings);
    $display("  %0d pass-through, %0d tone, %0d silent; %0d errors",
             n_passed, n_tone, n_silent, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### cadenced_tone_generator_core.f
rtl/core/ctg_pkg.sv
rtl/core/ctg_stream_if.sv
rtl/core/ctg_mul_unit.sv
rtl/core/cadenced_tone_generator_core.sv
tb/cadenced_tone_generator_core_test.sv
